### src/hmte_pkg.sv
// Package for the HMM transition matrix estimator.
// Holds field widths, parameter defaults, the controller state type and the
// command and status structs shared by the controller and the datapath.
package hmte_pkg;

  // Fixed widths of the transaction fields.
  localparam int unsigned STATE_BITS = 3;
  localparam int unsigned PROB_BITS  = 16;
  localparam logic [PROB_BITS-1:0] PROB_MAX = {PROB_BITS{1'b1}};

  // Defaults for the top-level parameters.
  localparam int unsigned DEF_NUM_STATES = 8;
  localparam int unsigned DEF_COUNT_BITS = 16;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_EM_READ,
    ST_EM_START,
    ST_EM_DIV,
    ST_EM_OUT
  } hmte_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;     // frame transaction taken this cycle
    logic upd;        // write back the incremented counts
    logic em_addr;    // address the count stores with the emission index
    logic div_start;  // load the divider with the entry just read
    logic out_load;   // move the finished entry into the output register
    logic clear;      // clear all counts after the final entry
  } hmte_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic frame_counts;  // offered frame forms a countable pair
    logic div_done;      // divider has finished
    logic entry_last;    // emission index is at the final entry
    logic out_free;      // output register can take an entry this cycle
  } hmte_stat_t;

endpackage

### src/hmte_if.sv
// Stream interfaces for frame input and matrix entry output.
// Depends on hmte_pkg for the field widths.
interface hmte_frame_if;
  logic                             valid;
  logic                             ready;
  logic [hmte_pkg::STATE_BITS-1:0]  state_number;
  logic                             last_frame;

  modport source (output valid, output state_number, output last_frame, input ready);
  modport sink   (input valid, input state_number, input last_frame, output ready);
endinterface

interface hmte_entry_if;
  logic                             valid;
  logic                             ready;
  logic [hmte_pkg::STATE_BITS-1:0]  to_state;
  logic [hmte_pkg::STATE_BITS-1:0]  from_state;
  logic [hmte_pkg::PROB_BITS-1:0]   probability;
  logic                             last_entry;

  modport source (output valid, output to_state, output from_state,
                  output probability, output last_entry, input ready);
  modport sink   (input valid, input to_state, input from_state,
                  input probability, input last_entry, output ready);
endinterface

### src/hmte_ctrl.sv
// Controller state machine of the HMM transition matrix estimator.
// Sequences frame counting and matrix emission; depends on hmte_pkg.
module hmte_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  frame_valid_i,
  input  logic                  frame_last_i,
  output logic                  frame_ready_o,
  input  hmte_pkg::hmte_stat_t  stat_i,
  output hmte_pkg::hmte_cmd_t   cmd_o
);
  import hmte_pkg::*;

  hmte_state_e state_q, state_d;
  logic        last_q, last_d;

  // State and pending end-of-sequence flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      last_q  <= last_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d       = state_q;
    last_d        = last_q;
    frame_ready_o = 1'b0;
    cmd_o         = '0;
    unique case (state_q)
      ST_IDLE: begin
        frame_ready_o = 1'b1;
        if (frame_valid_i) begin
          cmd_o.accept = 1'b1;
          last_d       = frame_last_i;
          if (stat_i.frame_counts) begin
            state_d = ST_UPDATE;
          end else if (frame_last_i) begin
            state_d = ST_EM_READ;
          end
        end
      end
      ST_UPDATE: begin
        cmd_o.upd = 1'b1;
        state_d   = last_q ? ST_EM_READ : ST_IDLE;
      end
      ST_EM_READ: begin
        cmd_o.em_addr = 1'b1;
        state_d       = ST_EM_START;
      end
      ST_EM_START: begin
        cmd_o.div_start = 1'b1;
        state_d         = ST_EM_DIV;
      end
      ST_EM_DIV: begin
        if (stat_i.div_done) begin
          state_d = ST_EM_OUT;
        end
      end
      ST_EM_OUT: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          if (stat_i.entry_last) begin
            cmd_o.clear = 1'b1;
            last_d      = 1'b0;
            state_d     = ST_IDLE;
          end else begin
            state_d = ST_EM_READ;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

### src/hmte_datapath.sv
// Datapath of the HMM transition matrix estimator: count stores, serial
// divider and output register. Depends on hmte_pkg; driven by hmte_ctrl.
module hmte_datapath #(
  parameter int unsigned NUM_STATES = hmte_pkg::DEF_NUM_STATES,
  parameter int unsigned COUNT_BITS = hmte_pkg::DEF_COUNT_BITS
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [hmte_pkg::PROB_BITS-1:0]   cfg_wdata_i,
  input  logic [hmte_pkg::STATE_BITS-1:0]  frame_state_i,
  input  hmte_pkg::hmte_cmd_t              cmd_i,
  output hmte_pkg::hmte_stat_t             stat_o,
  output logic                             entry_valid_o,
  input  logic                             entry_ready_i,
  output logic [hmte_pkg::STATE_BITS-1:0]  entry_to_o,
  output logic [hmte_pkg::STATE_BITS-1:0]  entry_from_o,
  output logic [hmte_pkg::PROB_BITS-1:0]   entry_prob_o,
  output logic                             entry_last_o
);
  import hmte_pkg::*;

  localparam int unsigned ST_W       = $clog2(NUM_STATES);
  localparam int unsigned PAIR_W     = 2 * ST_W;
  localparam int unsigned PAIR_DEPTH = 1 << PAIR_W;
  localparam int unsigned TOT_DEPTH  = 1 << ST_W;
  localparam int unsigned DIVC_W     = $clog2(PROB_BITS + 1);
  localparam logic [COUNT_BITS-1:0] CNT_MAX   = {COUNT_BITS{1'b1}};
  localparam logic [STATE_BITS:0]   NUM_ST_L  = (STATE_BITS + 1)'(NUM_STATES);
  localparam logic [ST_W-1:0]       ST_LAST   = ST_W'(NUM_STATES - 1);
  localparam logic [DIVC_W-1:0]     DIV_STEPS = DIVC_W'(PROB_BITS);

  // Configuration register.
  logic [PROB_BITS-1:0] min_prob_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_prob_q <= '0;
    end else if (cfg_we_i) begin
      min_prob_q <= cfg_wdata_i;
    end
  end

  // Frame decode: states outside the matrix are ignored.
  logic            s_ok;
  logic [ST_W-1:0] s_idx;
  logic [ST_W-1:0] prev_q;
  logic            have_prev_q;

  assign s_ok  = ({1'b0, frame_state_i} < NUM_ST_L);
  assign s_idx = frame_state_i[ST_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q      <= '0;
      have_prev_q <= 1'b0;
    end else if (cmd_i.clear) begin
      prev_q      <= '0;
      have_prev_q <= 1'b0;
    end else if (cmd_i.accept && s_ok) begin
      prev_q      <= s_idx;
      have_prev_q <= 1'b1;
    end
  end

  // Emission index: to-state outer, from-state inner.
  logic [ST_W-1:0] to_q, from_q;
  logic            entry_last;

  assign entry_last = (to_q == ST_LAST) && (from_q == ST_LAST);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      to_q   <= '0;
      from_q <= '0;
    end else if (cmd_i.out_load) begin
      if (entry_last) begin
        to_q   <= '0;
        from_q <= '0;
      end else if (from_q == ST_LAST) begin
        from_q <= '0;
        to_q   <= to_q + 1'b1;
      end else begin
        from_q <= from_q + 1'b1;
      end
    end
  end

  // Count stores with per-entry valid bits; an invalid entry reads as zero.
  logic [COUNT_BITS-1:0] pair_mem [PAIR_DEPTH];
  logic [COUNT_BITS-1:0] tot_mem  [TOT_DEPTH];
  logic [PAIR_DEPTH-1:0] pair_vld_q;
  logic [TOT_DEPTH-1:0]  tot_vld_q;
  logic [PAIR_W-1:0]     pair_raddr, pair_waddr_q;
  logic [ST_W-1:0]       tot_raddr, tot_waddr_q;
  logic [COUNT_BITS-1:0] pair_rd_q, tot_rd_q;
  logic                  pair_rv_q, tot_rv_q;
  logic [COUNT_BITS-1:0] pair_cnt, tot_cnt, pair_inc, tot_inc;

  assign pair_raddr = cmd_i.em_addr ? {to_q, from_q} : {s_idx, prev_q};
  assign tot_raddr  = cmd_i.em_addr ? from_q : prev_q;
  assign pair_cnt   = pair_rv_q ? pair_rd_q : '0;
  assign tot_cnt    = tot_rv_q ? tot_rd_q : '0;
  assign pair_inc   = (pair_cnt == CNT_MAX) ? CNT_MAX : pair_cnt + 1'b1;
  assign tot_inc    = (tot_cnt == CNT_MAX) ? CNT_MAX : tot_cnt + 1'b1;

  // Memory read and write ports.
  always_ff @(posedge clk_i) begin
    pair_rd_q <= pair_mem[pair_raddr];
    tot_rd_q  <= tot_mem[tot_raddr];
    if (cmd_i.upd) begin
      pair_mem[pair_waddr_q] <= pair_inc;
      tot_mem[tot_waddr_q]   <= tot_inc;
    end
  end

  // Write addresses are captured with the frame transaction.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      pair_waddr_q <= {s_idx, prev_q};
      tot_waddr_q  <= prev_q;
    end
  end

  // Valid bits, cleared at once after the final entry.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pair_vld_q <= '0;
      tot_vld_q  <= '0;
      pair_rv_q  <= 1'b0;
      tot_rv_q   <= 1'b0;
    end else begin
      pair_rv_q <= pair_vld_q[pair_raddr];
      tot_rv_q  <= tot_vld_q[tot_raddr];
      if (cmd_i.clear) begin
        pair_vld_q <= '0;
        tot_vld_q  <= '0;
      end else if (cmd_i.upd) begin
        pair_vld_q[pair_waddr_q] <= 1'b1;
        tot_vld_q[tot_waddr_q]   <= 1'b1;
      end
    end
  end

  // Restoring divider, one quotient bit per cycle. Since a pair count never
  // exceeds its total, only an equal count reaches a ratio of one.
  logic [COUNT_BITS-1:0] rem_q, dvs_q;
  logic [PROB_BITS-1:0]  quo_q;
  logic [DIVC_W-1:0]     div_cnt_q;
  logic                  zero_q, full_q;
  logic [COUNT_BITS:0]   rem_dbl, rem_sub;
  logic                  div_zero, div_full;

  assign rem_dbl  = {rem_q, 1'b0};
  assign rem_sub  = rem_dbl - {1'b0, dvs_q};
  assign div_zero = (tot_cnt == '0);
  assign div_full = !div_zero && (pair_cnt >= tot_cnt);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_cnt_q <= '0;
    end else if (cmd_i.div_start) begin
      div_cnt_q <= (div_zero || div_full) ? '0 : DIV_STEPS;
    end else if (div_cnt_q != '0) begin
      div_cnt_q <= div_cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      rem_q  <= pair_cnt;
      dvs_q  <= tot_cnt;
      quo_q  <= '0;
      zero_q <= div_zero;
      full_q <= div_full;
    end else if (div_cnt_q != '0) begin
      if (rem_dbl >= {1'b0, dvs_q}) begin
        rem_q <= rem_sub[COUNT_BITS-1:0];
        quo_q <= {quo_q[PROB_BITS-2:0], 1'b1};
      end else begin
        rem_q <= rem_dbl[COUNT_BITS-1:0];
        quo_q <= {quo_q[PROB_BITS-2:0], 1'b0};
      end
    end
  end

  // Final probability with the configured floor.
  logic [PROB_BITS-1:0] prob;

  always_comb begin
    if (zero_q) begin
      prob = min_prob_q;
    end else if (full_q) begin
      prob = PROB_MAX;
    end else if (quo_q < min_prob_q) begin
      prob = min_prob_q;
    end else begin
      prob = quo_q;
    end
  end

  // Output register.
  logic                  out_valid_q;
  logic [STATE_BITS-1:0] out_to_q, out_from_q;
  logic [PROB_BITS-1:0]  out_prob_q;
  logic                  out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (entry_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_to_q   <= STATE_BITS'(to_q);
      out_from_q <= STATE_BITS'(from_q);
      out_prob_q <= prob;
      out_last_q <= entry_last;
    end
  end

  assign entry_valid_o = out_valid_q;
  assign entry_to_o    = out_to_q;
  assign entry_from_o  = out_from_q;
  assign entry_prob_o  = out_prob_q;
  assign entry_last_o  = out_last_q;

  // Status to the controller.
  assign stat_o.frame_counts = s_ok && have_prev_q;
  assign stat_o.div_done     = (div_cnt_q == '0);
  assign stat_o.entry_last   = entry_last;
  assign stat_o.out_free     = !out_valid_q || entry_ready_i;

`ifndef SYNTHESIS
  // An entry is only loaded when the output register is free.
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> (!out_valid_q || entry_ready_i))
    else $error("entry loaded over an untaken entry");

  // A count write-back always follows a frame transaction directly.
  a_upd_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.upd |-> $past(cmd_i.accept))
    else $error("count write-back without a preceding frame");

  // A loaded probability never lies below the floor.
  a_prob_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |=> (out_prob_q >= min_prob_q))
    else $error("probability below the configured floor");

  // Clearing ends the sequence and restarts the emission index.
  a_clear_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clear |=> (!have_prev_q && (to_q == '0) && (from_q == '0)))
    else $error("sequence state not cleared after the final entry");
`endif

endmodule

### src/hmm_transition_matrix_estimator.sv
// Top level of the HMM transition matrix estimator.
// Joins hmte_ctrl and hmte_datapath; depends on hmte_pkg and hmte_if.
//
//   Channel   Direction  Transaction contents
//   frame_i   in         state_number, last_frame
//   entry_o   out        to_state, from_state, probability, last_entry
//   cfg       in         min_probability (write enable and data, no index)
//
// A frame that forms a countable pair is read from the count stores and then
// written back before the next frame is taken; any other frame needs no write-back.
// Each matrix entry takes a store read, a divider load and one step of the
// bit-serial divider per probability bit; a never-left or certain entry skips the steps.
// Counts are cleared at once through per-entry valid bits, so there is
// no clearing pass after reset. The final entry may wait in the output
// register while the next frame is already accepted.
module hmm_transition_matrix_estimator #(
  parameter int unsigned NUM_STATES = hmte_pkg::DEF_NUM_STATES,
  parameter int unsigned COUNT_BITS = hmte_pkg::DEF_COUNT_BITS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [hmte_pkg::PROB_BITS-1:0]  cfg_wdata_i,
  hmte_frame_if.sink                      frame_i,
  hmte_entry_if.source                    entry_o
);
  import hmte_pkg::*;

  hmte_cmd_t  cmd;
  hmte_stat_t stat;
  logic       frame_ready;

  // Control sequencing.
  hmte_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .frame_valid_i (frame_i.valid),
    .frame_last_i  (frame_i.last_frame),
    .frame_ready_o (frame_ready),
    .stat_i        (stat),
    .cmd_o         (cmd)
  );

  assign frame_i.ready = frame_ready;

  // Counting, division and output storage.
  hmte_datapath #(
    .NUM_STATES (NUM_STATES),
    .COUNT_BITS (COUNT_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .frame_state_i (frame_i.state_number),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .entry_valid_o (entry_o.valid),
    .entry_ready_i (entry_o.ready),
    .entry_to_o    (entry_o.to_state),
    .entry_from_o  (entry_o.from_state),
    .entry_prob_o  (entry_o.probability),
    .entry_last_o  (entry_o.last_entry)
  );

endmodule

### bench/tb_hmm_transition_matrix_estimator.sv
// Self-checking testbench for hmm_transition_matrix_estimator.
// Drives frame sequences, predicts every matrix entry and checks the entry stream.
// Depends on hmte_pkg, hmte_if and the block itself.
module tb_hmm_transition_matrix_estimator;

  localparam int unsigned NUM_STATES = hmte_pkg::DEF_NUM_STATES;
  localparam int unsigned COUNT_BITS = hmte_pkg::DEF_COUNT_BITS;
  localparam longint unsigned COUNT_MAX = (64'd1 << COUNT_BITS) - 64'd1;
  localparam longint unsigned PROB_SAT = 64'(hmte_pkg::PROB_MAX);
  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int unsigned HOLD_CYCLES = 600;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned RANDOM_FRAMES = 400;
  localparam int unsigned MAX_PRINTED = 40;

  typedef struct packed {
    logic [hmte_pkg::STATE_BITS-1:0] state_number;
    logic                            last_frame;
  } frame_t;

  typedef struct packed {
    logic [hmte_pkg::STATE_BITS-1:0] to_state;
    logic [hmte_pkg::STATE_BITS-1:0] from_state;
    logic [hmte_pkg::PROB_BITS-1:0]  probability;
    logic                            last_entry;
  } entry_t;

  logic                           clk_i = 1'b0;
  logic                           rst_ni;
  logic                           cfg_we_i;
  logic [hmte_pkg::PROB_BITS-1:0] cfg_wdata_i;

  hmte_frame_if frame_bus ();
  hmte_entry_if entry_bus ();

  hmm_transition_matrix_estimator u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .frame_i    (frame_bus),
    .entry_o    (entry_bus)
  );

  // Frames waiting to be offered and matrix entries waiting to come out.
  frame_t pending_frames[$];
  entry_t expected_entries[$];

  // Shadow of the transition counts and the probability floor.
  int unsigned                    pair_count [8][8];
  int unsigned                    leave_total [8];
  int unsigned                    prev_state;
  bit                             have_prev;
  logic [hmte_pkg::PROB_BITS-1:0] floor_q16;

  // Run control and statistics.
  bit          steady_flow = 1'b0;
  bit          hold_request = 1'b0;
  bit          hold_spent = 1'b0;
  int unsigned hold_left = 0;
  int unsigned cycle_count = 0;
  int unsigned mismatch_count = 0;
  int unsigned frames_accepted = 0;
  int unsigned matrices_predicted = 0;
  int unsigned entries_checked = 0;

  always #2 clk_i = ~clk_i;

  // Print one line per mismatch, up to a cap, and count every one.
  task automatic flag_mismatch(input string msg);
    if (mismatch_count < MAX_PRINTED) begin
      $display("[%0d] %s", cycle_count, msg);
    end
    mismatch_count++;
  endtask

  // Count one accepted frame and, on the last frame, predict the whole matrix.
  task automatic tally_frame(input logic [hmte_pkg::STATE_BITS-1:0] s, input logic last);
    longint unsigned ratio;
    entry_t          e;
    frames_accepted++;
    if (s < NUM_STATES) begin
      if (have_prev) begin
        if (pair_count[s][prev_state] < COUNT_MAX) pair_count[s][prev_state]++;
        if (leave_total[prev_state] < COUNT_MAX) leave_total[prev_state]++;
      end
      prev_state = s;
      have_prev = 1'b1;
    end
    if (last) begin
      for (int unsigned t = 0; t < NUM_STATES; t++) begin
        for (int unsigned f = 0; f < NUM_STATES; f++) begin
          // A from-state that was never left yields the floor.
          if (leave_total[f] == 0) begin
            ratio = 64'(floor_q16);
          end else begin
            ratio = (64'(pair_count[t][f]) << 16) / 64'(leave_total[f]);
            if (ratio > PROB_SAT) ratio = PROB_SAT;
            if (ratio < 64'(floor_q16)) ratio = 64'(floor_q16);
          end
          e.to_state    = 3'(t);
          e.from_state  = 3'(f);
          e.probability = ratio[hmte_pkg::PROB_BITS-1:0];
          e.last_entry  = (t == NUM_STATES - 1) && (f == NUM_STATES - 1);
          expected_entries.push_back(e);
        end
      end
      foreach (pair_count[t, f]) pair_count[t][f] = 0;
      foreach (leave_total[f]) leave_total[f] = 0;
      prev_state = 0;
      have_prev = 1'b0;
      matrices_predicted++;
    end
  endtask

  task automatic push_frame(input int unsigned s, input bit last);
    frame_t f;
    f.state_number = 3'(s);
    f.last_frame   = last;
    pending_frames.push_back(f);
  endtask

  // Queue a run of frames drawn from a random window of neighboring states.
  task automatic queue_sequence(input int unsigned len, input bit close);
    int unsigned base;
    int unsigned span;
    base = $urandom_range(0, NUM_STATES - 1);
    span = $urandom_range(1, NUM_STATES);
    for (int unsigned k = 0; k < len; k++) begin
      push_frame((base + $urandom_range(0, span - 1)) % NUM_STATES, close && (k == len - 1));
    end
  endtask

  // Wait until every frame is taken and every predicted entry has come out.
  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_frames.size() != 0 || frame_bus.valid || expected_entries.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Program the floor; only called while the block is idle.
  task automatic write_floor(input logic [hmte_pkg::PROB_BITS-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    floor_q16 = value;
  endtask

  // Frame driver: offers the next queued frame, with random gaps.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      frame_bus.valid <= 1'b0;
    end else if (!frame_bus.valid || frame_bus.ready) begin
      if (pending_frames.size() != 0 && (steady_flow || $urandom_range(99) >= 30)) begin
        frame_bus.valid        <= 1'b1;
        frame_bus.state_number <= pending_frames[0].state_number;
        frame_bus.last_frame   <= pending_frames[0].last_frame;
        void'(pending_frames.pop_front());
      end else begin
        frame_bus.valid <= 1'b0;
      end
    end
  end

  // Predict on every accepted frame transaction.
  always @(posedge clk_i) begin
    if (rst_ni && frame_bus.valid && frame_bus.ready) begin
      tally_frame(frame_bus.state_number, frame_bus.last_frame);
    end
  end

  // Long receiver hold-off, counted down once when requested.
  always @(posedge clk_i) begin
    if (hold_request && !hold_spent) begin
      hold_left  <= HOLD_CYCLES;
      hold_spent <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Entry receiver: random back-pressure outside the hold-off.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      entry_bus.ready <= 1'b0;
    end else begin
      entry_bus.ready <= (hold_left == 0) && (steady_flow || $urandom_range(99) >= 30);
    end
  end

  // Check each accepted entry transaction against the oldest prediction.
  always @(posedge clk_i) begin : check_entry
    entry_t want;
    if (rst_ni && entry_bus.valid && entry_bus.ready) begin
      if (expected_entries.size() == 0) begin
        flag_mismatch($sformatf("unexpected entry to=%0d from=%0d prob=%h",
                                entry_bus.to_state, entry_bus.from_state,
                                entry_bus.probability));
      end else begin
        want = expected_entries.pop_front();
        if (entry_bus.to_state !== want.to_state)
          flag_mismatch($sformatf("to_state got %0d want %0d",
                                  entry_bus.to_state, want.to_state));
        if (entry_bus.from_state !== want.from_state)
          flag_mismatch($sformatf("from_state got %0d want %0d",
                                  entry_bus.from_state, want.from_state));
        if (entry_bus.probability !== want.probability)
          flag_mismatch($sformatf("probability at (%0d,%0d) got %h want %h",
                                  want.to_state, want.from_state,
                                  entry_bus.probability, want.probability));
        if (entry_bus.last_entry !== want.last_entry)
          flag_mismatch($sformatf("last_entry at (%0d,%0d) got %b want %b",
                                  want.to_state, want.from_state,
                                  entry_bus.last_entry, want.last_entry));
        entries_checked++;
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d entries still expected",
               cycle_count, expected_entries.size());
      $display("hmm_transition_matrix_estimator: mismatch");
      $finish;
    end
  end

  // Stimulus: directed sequences, then random phases.
  initial begin : stimulus
    int unsigned phase_frames;
    int unsigned random_frames;
    int unsigned len;
    logic [hmte_pkg::PROB_BITS-1:0] phase_floor;

    rst_ni                 = 1'b0;
    cfg_we_i               = 1'b0;
    cfg_wdata_i            = '0;
    frame_bus.valid        = 1'b0;
    frame_bus.state_number = '0;
    frame_bus.last_frame   = 1'b0;
    entry_bus.ready        = 1'b0;
    floor_q16              = '0;
    foreach (pair_count[t, f]) pair_count[t][f] = 0;
    foreach (leave_total[f]) leave_total[f] = 0;
    prev_state = 0;
    have_prev  = 1'b0;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset floor of zero: one-frame sequence, alternating extremes,
    // a certain self-transition, and a walk through every state.
    push_frame(5, 1'b1);
    push_frame(7, 1'b0);
    push_frame(0, 1'b0);
    push_frame(7, 1'b1);
    push_frame(2, 1'b0);
    push_frame(2, 1'b0);
    push_frame(2, 1'b1);
    for (int unsigned k = 0; k < NUM_STATES; k++) push_frame(k, 1'b0);
    push_frame(1, 1'b1);
    wait_drained();

    // Floor at full scale pins every entry.
    write_floor(16'hFFFF);
    push_frame(6, 1'b0);
    push_frame(1, 1'b0);
    push_frame(6, 1'b1);
    wait_drained();

    // A floor above a quarter lifts the zero entries; the rare transition, at a third, stays above it.
    write_floor(16'h5000);
    push_frame(0, 1'b0);
    push_frame(1, 1'b0);
    push_frame(0, 1'b0);
    push_frame(1, 1'b0);
    push_frame(0, 1'b0);
    push_frame(2, 1'b1);
    wait_drained();

    // Random phases, each under its own floor and flow pattern.
    random_frames = 0;
    for (int unsigned phase = 0; random_frames < RANDOM_FRAMES; phase++) begin
      case (phase % 5)
        0: phase_floor = 16'($urandom_range(1, 16'h0FFF));
        1: phase_floor = 16'h8000;
        2: phase_floor = 16'($urandom());
        3: phase_floor = 16'h0000;
        default: phase_floor = 16'($urandom_range(0, 255));
      endcase
      write_floor(phase_floor);
      if (phase % 5 == 1) hold_request <= 1'b1;
      steady_flow <= (phase % 5 == 2);
      phase_frames = 0;
      while (phase_frames < 80) begin
        len = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 24);
        queue_sequence(len, 1'b1);
        phase_frames += len;
      end
      // Sometimes leave a sequence open across the floor change.
      if ($urandom_range(0, 1) == 1) begin
        len = $urandom_range(1, 3);
        queue_sequence(len, 1'b0);
        phase_frames += len;
      end
      random_frames += phase_frames;
      wait_drained();
      steady_flow <= 1'b0;
    end

    wait_drained();
    repeat (40) @(posedge clk_i);
    $display("Run covered %0d frames, %0d predicted matrices, %0d entries checked.",
             frames_accepted, matrices_predicted, entries_checked);
    $display("Floors from zero to full scale, one-frame sequences, a long output stall.");
    if (mismatch_count == 0) begin
      $display("hmm_transition_matrix_estimator: match");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("hmm_transition_matrix_estimator: mismatch");
    end
    $finish;
  end

endmodule
